>>> sv/pcs_pkg.sv
`default_nettype none

package pcs_pkg;

  // Fixed field widths of the request and result.
  localparam int unsigned LIMIT_W = 17;
  localparam int unsigned COUNT_W = 16;

  // The count saturates at the largest value the result field can carry.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // One sieve flag.
  typedef logic flag_t;

  localparam flag_t FLAG_CANDIDATE = 1'b1;
  localparam flag_t FLAG_COMPOSITE = 1'b0;

endpackage

`default_nettype wire

>>> sv/prime_count_sieve.sv
`default_nettype none

// Counts the primes strictly below the requested limit with the sieve of
// Eratosthenes over a one-bit flag memory of MAX_N entries; a limit above
// MAX_N is treated as MAX_N, a limit of zero or one returns 0, and the count
// saturates at 65535. One request is worked at a time, and every cycle
// writes or checks at most one flag. A finished count waits while the
// previous result still holds the output register. The flag memory needs
// no clearing after reset, since each request writes every flag below its
// limit before reading it. A new request can be taken while the previous
// result still waits on the output register.
module prime_count_sieve #(
  parameter int unsigned MAX_N = 65536
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [pcs_pkg::LIMIT_W-1:0]    limit,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [pcs_pkg::COUNT_W-1:0]    prime_count
);

  localparam int unsigned NW = $clog2(MAX_N + 1);
  localparam int unsigned IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int unsigned LW = (NW > pcs_pkg::LIMIT_W) ? NW : pcs_pkg::LIMIT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_MARK = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]                  state;
  logic [NW-1:0]               n_lim;
  logic [NW-1:0]               idx;
  logic [NW:0]                 j;
  logic [pcs_pkg::COUNT_W-1:0] count;

  logic [LW-1:0]               lim_ext;
  logic [NW-1:0]               n_req;
  logic                        mark_live;

  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  pcs_pkg::flag_t              ram_wdata;
  logic [IW-1:0]               ram_raddr;
  pcs_pkg::flag_t              ram_rdata;

  // Effective limit, saturated to the size of the flag memory.
  assign lim_ext = LW'(limit);
  assign n_req   = (lim_ext > LW'(MAX_N)) ? NW'(LW'(MAX_N)) : NW'(lim_ext);

  // Marking continues while the multiple pointer stays below the limit.
  assign mark_live = (j < {1'b0, n_lim});

  // Only the idle state takes a transfer.
  assign in_stall = (state != ST_IDLE);

  // Flag memory access: the fill pass writes, the mark pass clears, the scan reads.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[IW-1:0];
    ram_wdata = pcs_pkg::FLAG_COMPOSITE;
    if (state == ST_INIT) begin
      ram_we    = 1'b1;
      ram_wdata = (idx >= NW'(2)) ? pcs_pkg::FLAG_CANDIDATE : pcs_pkg::FLAG_COMPOSITE;
    end else if (state == ST_MARK) begin
      ram_we    = mark_live;
      ram_waddr = j[IW-1:0];
    end
  end

  assign ram_raddr = idx[IW-1:0];

  pcs_flag_ram #(
    .DEPTH  (MAX_N),
    .ADDR_W (IW)
  ) u_flag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sieve sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The output register loads a finished count and empties on a result transfer.
      if (state == ST_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            n_lim <= n_req;
            idx   <= '0;
            count <= '0;
            state <= (n_req < NW'(2)) ? ST_FIN : ST_INIT;
          end
        end
        ST_INIT: begin
          if (idx == n_lim - NW'(1)) begin
            idx   <= NW'(2);
            state <= ST_RD;
          end else begin
            idx <= idx + NW'(1);
          end
        end
        ST_RD: begin
          state <= (idx >= n_lim) ? ST_FIN : ST_CHK;
        end
        ST_CHK: begin
          if (ram_rdata == pcs_pkg::FLAG_CANDIDATE) begin
            if (count != pcs_pkg::COUNT_MAX) begin
              count <= count + pcs_pkg::COUNT_W'(1);
            end
            j     <= {idx, 1'b0};
            state <= ST_MARK;
          end else begin
            idx   <= idx + NW'(1);
            state <= ST_RD;
          end
        end
        ST_MARK: begin
          if (mark_live) begin
            j <= j + (NW + 1)'(idx);
          end else begin
            idx   <= idx + NW'(1);
            state <= ST_RD;
          end
        end
        ST_FIN: begin
          if (!out_valid || !out_stall) begin
            prime_count <= count;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Every flag write lands below the active limit.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ({1'b0, ram_waddr} < (IW + 1)'(n_lim)))
    else $error("flag write outside the active limit");

  // The multiple pointer never falls below twice the current prime.
  a_mark_from_double: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK) |-> (j >= {idx, 1'b0}))
    else $error("mark pointer below twice the prime");

  // The scan only inspects indices below the limit.
  a_check_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHK) |-> (idx < n_lim))
    else $error("scan checked an index beyond the limit");

  // The prime count never drops while a request is in work.
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && $past(state) != ST_IDLE) |-> (count >= $past(count)))
    else $error("prime count decreased within a request");

  // A finished request with a free output register presents its result next cycle.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !out_valid) |=> (out_valid && state == ST_IDLE))
    else $error("finished result not loaded into the output register");

endmodule

`default_nettype wire

>>> sv/pcs_flag_ram.sv
`default_nettype none

module pcs_flag_ram #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire pcs_pkg::flag_t    wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output pcs_pkg::flag_t         rdata
);

  pcs_pkg::flag_t mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sim/prime_count_monitor.sv
`timescale 1ns / 1ps

// Watches both channels of the sieve, predicts the prime count of every
// accepted request and compares it with the result that comes back.
module prime_count_monitor #(
  parameter int unsigned MAX_N = 65536
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic [pcs_pkg::LIMIT_W-1:0] limit,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [pcs_pkg::COUNT_W-1:0] prime_count,
  output int unsigned                      error_count,
  output int unsigned                      pending_count,
  output int unsigned                      checked_count
);

  typedef struct {
    logic [pcs_pkg::LIMIT_W-1:0] limit;
    logic [pcs_pkg::COUNT_W-1:0] count;
  } count_entry_t;

  // Counts still owed by the block, oldest first.
  count_entry_t expected_counts [$];

  // Private flag store for the prediction; every flag is written before use.
  pcs_pkg::flag_t sieve_flags [MAX_N];

  // Sieve of Eratosthenes over the effective limit, saturating as the block does.
  function automatic logic [pcs_pkg::COUNT_W-1:0] count_primes_below(
      input logic [pcs_pkg::LIMIT_W-1:0] req);
    int unsigned n;
    int unsigned i;
    int unsigned j;
    int unsigned total;
    n = (req > MAX_N) ? MAX_N : int'(req);
    total = 0;
    if (n >= 2) begin
      for (i = 0; i < n; i++) sieve_flags[i] = pcs_pkg::FLAG_CANDIDATE;
      sieve_flags[0] = pcs_pkg::FLAG_COMPOSITE;
      sieve_flags[1] = pcs_pkg::FLAG_COMPOSITE;
      for (i = 2; i < n; i++) begin
        if (sieve_flags[i] == pcs_pkg::FLAG_CANDIDATE) begin
          if (total < pcs_pkg::COUNT_MAX) total++;
          for (j = 2 * i; j < n; j += i) sieve_flags[j] = pcs_pkg::FLAG_COMPOSITE;
        end
      end
    end
    return total[pcs_pkg::COUNT_W-1:0];
  endfunction

  // Record each request transfer and check each result transfer in order.
  always @(posedge clk) begin
    count_entry_t entry;
    count_entry_t oldest;
    if (rst) begin
      expected_counts.delete();
      error_count <= 0;
      pending_count <= 0;
      checked_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        entry.limit = limit;
        entry.count = count_primes_below(limit);
        expected_counts.push_back(entry);
      end
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected prime_count transfer: expected none, actual %0d",
                   $time, prime_count);
          error_count <= error_count + 1;
        end else begin
          oldest = expected_counts.pop_front();
          checked_count <= checked_count + 1;
          if (prime_count !== oldest.count) begin
            $display("%0t: prime_count mismatch for limit %0d: expected %0d, actual %0d",
                     $time, oldest.limit, oldest.count, prime_count);
            error_count <= error_count + 1;
          end
        end
      end
      pending_count <= expected_counts.size();
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MAX_N = 65536;
  localparam int unsigned RANDOM_REQUESTS = 100;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [pcs_pkg::LIMIT_W-1:0] limit;
  logic                        out_valid;
  logic                        out_stall;
  logic [pcs_pkg::COUNT_W-1:0] prime_count;

  // While set, neither side inserts idle cycles.
  logic               quiet;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned sent_count;
  int unsigned widest_limit;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  prime_count_sieve #(
    .MAX_N(MAX_N)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .limit(limit),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .prime_count(prime_count)
  );

  prime_count_monitor #(
    .MAX_N(MAX_N)
  ) u_monitor (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .limit(limit),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .prime_count(prime_count),
    .error_count(error_count),
    .pending_count(pending_count),
    .checked_count(checked_count)
  );

  // The result side holds off at random except during the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 22);
  end

  // Offer one limit, after a random idle gap, and hold it until the transfer.
  task automatic send_request(input logic [pcs_pkg::LIMIT_W-1:0] value);
    int unsigned gap;
    gap = 0;
    while (!quiet && $urandom_range(99) < 22) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    limit <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (32'(value) > widest_limit) widest_limit = 32'(value);
  endtask

  // Mostly small limits to keep the run short; every twelfth one is larger.
  function automatic logic [pcs_pkg::LIMIT_W-1:0] pick_limit(input int unsigned index);
    if (index % 12 == 5) return pcs_pkg::LIMIT_W'($urandom_range(8191, 1024));
    if ($urandom_range(9) == 0) return pcs_pkg::LIMIT_W'($urandom_range(3));
    return pcs_pkg::LIMIT_W'($urandom_range(1023));
  endfunction

  // Stimulus and verdict.
  initial begin
    logic [pcs_pkg::LIMIT_W-1:0] directed_limits [$];
    rst = 1'b1;
    in_valid = 1'b0;
    limit = '0;
    quiet = 1'b0;
    sent_count = 0;
    widest_limit = 0;
    // Zero and one, the smallest real sieves, a few primes at the edge of
    // the limit, the full store and a limit above it that must saturate.
    directed_limits = {17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd11, 17'd12,
                       17'd13, 17'd100, 17'd1021, 17'd131071, 17'd65536};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_limits[k]) send_request(directed_limits[k]);

    for (int unsigned k = 0; k < RANDOM_REQUESTS; k++) begin
      quiet <= (k >= 30) && (k < 50);
      send_request(pick_limit(k));
    end
    in_valid <= 1'b0;
    quiet <= 1'b0;
    @(posedge clk);

    // Drain the outstanding counts, then allow a short settle.
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d limit requests up to %0d (full store and saturation included),",
             sent_count, widest_limit);
    $display("with %0d prime counts compared against the prediction.", checked_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #200_000_000;
    $display("Timeout: prime counts still outstanding");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
